>>> hw/rtl/bpb_pkg.sv
`default_nettype none
package bpb_pkg;
  localparam int BtbSets     = 1024;
  localparam int BtbWays     = 4;
  localparam int PhtEntries  = 1024;
  localparam int SetW        = $clog2(BtbSets);
  localparam int WayW        = (BtbWays > 1) ? $clog2(BtbWays) : 1;
  localparam int PhtW        = $clog2(PhtEntries);
  localparam int HistW       = 10;
  localparam int PcW         = 48;
  localparam int StampW      = 40;
  localparam int RowW        = BtbWays * (PcW + StampW);
  localparam int ClrCycles   = (BtbSets > PhtEntries) ? BtbSets : PhtEntries;
  localparam int ClrW        = $clog2(ClrCycles + 1);
  localparam logic [1:0] CtrMax   = 2'd3;
  localparam logic [1:0] NtbReset = 2'd3;
  localparam logic [1:0] CfgMispredict = 2'd0;
  localparam logic [1:0] CfgBtbMiss    = 2'd1;

  typedef struct packed {
    logic clear;     // clearing pass write
    logic lookup;    // issue table reads for the held item
    logic update;    // evaluate and write back
  } bpb_cmd_t;

  typedef struct packed {
    logic clear_done;
  } bpb_sts_t;

  function automatic logic [1:0] sat_move(input logic [1:0] v, input logic up);
    if (up) return (v == CtrMax) ? CtrMax : v + 2'd1;
    return (v == 2'd0) ? 2'd0 : v - 2'd1;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/bpb_ctrl.sv
`default_nettype none
module bpb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_free,
  input  wire bpb_pkg::bpb_sts_t sts,
  output bpb_pkg::bpb_cmd_t    cmd,
  output logic                 in_ready
);
  import bpb_pkg::*;
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_UPD} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_READ;
      S_READ:  state_nxt = S_UPD;
      S_UPD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.clear   = (state_r == S_CLEAR);
  assign cmd.lookup  = (state_r == S_READ);
  assign cmd.update  = (state_r == S_UPD) && out_free;

  a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && !sts.clear_done) |=> state_r == S_CLEAR) else $error("clear exit");
  a_read_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_UPD) else $error("read seq");
  a_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_fire) else $error("accept while busy");
endmodule
`default_nettype wire

>>> hw/rtl/bpb_dp.sv
`default_nettype none
module bpb_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpb_pkg::bpb_cmd_t cmd,
  output bpb_pkg::bpb_sts_t      sts,
  input  wire logic              in_fire,
  input  wire logic              is_branch,
  input  wire logic              is_cond,
  input  wire logic [47:0]       pc,
  input  wire logic [3:0]        instr_size,
  input  wire logic [47:0]       next_pc,
  input  wire logic [39:0]       time_stamp,
  input  wire logic [7:0]        mis_pen,
  input  wire logic [7:0]        miss_pen,
  output logic                   res_load,
  output logic [11:0]            res
);
  import bpb_pkg::*;
  logic [RowW-1:0]  btb_mem [BtbSets];
  logic [1:0]       ch_mem [PhtEntries];
  logic [1:0]       dt_mem [PhtEntries];
  logic [1:0]       dn_mem [PhtEntries];
  logic [ClrW-1:0]  clr_r;
  logic             br_r, cond_r;
  logic [47:0]      pc_r, npc_r;
  logic [3:0]       sz_r;
  logic [39:0]      ts_r;
  logic [HistW-1:0] hist_r;
  logic [RowW-1:0]  row_q;
  logic [1:0]       ch_q, dt_q, dn_q;
  logic [SetW-1:0]  set_r;
  logic [PhtW-1:0]  idx_r;

  assign sts.clear_done = (clr_r == ClrW'(ClrCycles - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear && !sts.clear_done) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      br_r <= is_branch; cond_r <= is_cond; pc_r <= pc;
      npc_r <= next_pc; sz_r <= instr_size; ts_r <= time_stamp;
      set_r <= pc[SetW-1:0];
      idx_r <= PhtW'((pc[9:0] ^ hist_r) % PhtEntries);
    end
  end

  // hit and victim search
  logic            hit;
  logic [WayW-1:0] hway, vway;
  logic [39:0]     oldest;
  always_comb begin
    logic [PcW-1:0] tg; logic [StampW-1:0] st;
    hit = 1'b0; hway = '0; vway = '0; oldest = '1;
    for (int w = 0; w < BtbWays; w++) begin
      tg = row_q[w*(PcW+StampW) +: PcW];
      st = row_q[w*(PcW+StampW)+PcW +: StampW];
      if (!hit) begin
        if (tg == pc_r) begin hit = 1'b1; hway = WayW'(w); end
        else if (st < oldest || (w == 0)) begin
          oldest = st; vway = WayW'(w);
        end
      end
    end
  end

  logic       bank, guess, taken, correct, dis, pred;
  logic [1:0] dsel;
  logic [RowW-1:0] row_new;
  logic [WayW-1:0] uw;
  assign bank    = ch_q[1];
  assign dsel    = bank ? dn_q : dt_q;
  assign guess   = ~dsel[1];
  assign taken   = ({1'b0, pc_r} + 49'(sz_r)) != {1'b0, npc_r};
  assign correct = guess == taken;
  assign dis     = bank ? taken : ~taken;
  assign pred    = br_r && hit && cond_r;
  assign uw      = hit ? hway : vway;
  always_comb begin
    row_new = row_q;
    row_new[uw*(PcW+StampW) +: PcW] = pc_r;
    row_new[uw*(PcW+StampW)+PcW +: StampW] = ts_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      btb_mem[clr_r[SetW-1:0]] <= '0;
      ch_mem[clr_r[PhtW-1:0]]  <= '0;
      dt_mem[clr_r[PhtW-1:0]]  <= '0;
      dn_mem[clr_r[PhtW-1:0]]  <= NtbReset;
    end else if (cmd.update) begin
      if (br_r) btb_mem[set_r] <= row_new;
      if (pred) begin
        if (!(correct && dis)) ch_mem[idx_r] <= sat_move(ch_q, ~taken);
        if (bank) dn_mem[idx_r] <= sat_move(dn_q, ~taken);
        else dt_mem[idx_r] <= sat_move(dt_q, ~taken);
      end
    end
    if (cmd.lookup) begin
      row_q <= btb_mem[set_r];
      ch_q <= ch_mem[idx_r]; dt_q <= dt_mem[idx_r]; dn_q <= dn_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hist_r <= '0;
    else if (cmd.update && pred) hist_r <= {hist_r[HistW-2:0], correct};
  end

  assign res_load = cmd.update;
  // hit, pred, pred_taken, mis, stall
  always_comb begin
    res = '0;
    if (br_r) begin
      res[0] = hit;
      if (!hit) res[11:4] = miss_pen;
      else if (pred) begin
        res[1] = 1'b1; res[2] = guess; res[3] = ~correct;
        res[11:4] = correct ? 8'd0 : mis_pen;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/bimode_predictor_btb.sv
`default_nettype none
// bimode branch predictor with a 4-way set-associative btb (full-pc tags,
// lru stamps). one result per input transfer. an item goes through accept, table read, and
// update and result load, which waits while the output register is full; the next transfer is
// taken only after that, set by the single-port read-modify-write of the btb row and pht counters.
// after reset a clearing pass over all 1024 btb sets and pht entries initializes the memories;
// no input transfer is taken during it, config writes are.
module bimode_predictor_btb (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,  // is_conditional, pc, instr_size, next_pc, time_stamp
  input  wire logic         in_tuser,  // is_branch
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata, // btb_hit, predicted, predicted_taken, mispredicted, stall_cycles
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [7:0]   cfg_wdata
);
  import bpb_pkg::*;
  logic [7:0] mis_pen_r, miss_pen_r;
  bpb_cmd_t cmd;
  bpb_sts_t sts;
  logic in_fire, out_free, res_load;
  logic [11:0] res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mis_pen_r <= 8'd14; miss_pen_r <= 8'd14;
    end else if (cfg_we) begin
      if (cfg_index == CfgMispredict[0:0]) mis_pen_r <= cfg_wdata;
      if (cfg_index == CfgBtbMiss[0:0]) miss_pen_r <= cfg_wdata;
    end
  end

  assign in_fire  = in_tvalid && in_tready;
  // output register frees when empty or being taken
  assign out_free = !out_tvalid || out_tready;

  bpb_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .in_ready(in_tready));

  bpb_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_fire,
    .is_branch(in_tuser), .is_cond(in_tdata[0]), .pc(in_tdata[48:1]),
    .instr_size(in_tdata[52:49]), .next_pc(in_tdata[100:53]),
    .time_stamp(in_tdata[140:101]),
    .mis_pen(mis_pen_r), .miss_pen(miss_pen_r), .res_load, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (res_load) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) out_tdata <= {4'd0, res};
  end
endmodule
`default_nettype wire

>>> sim/tb.sv
`default_nettype none
module tb;
  import bpb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        is_branch;
    logic        is_cond;
    logic [47:0] pc;
    logic [3:0]  size;
    logic [47:0] next_pc;
    logic [39:0] stamp;
  } branch_rec_t;

  // packed from msb down so that hit lands in bit 0, as on the port
  typedef struct packed {
    logic [7:0] stall;
    logic       mispred;
    logic       pred_taken;
    logic       pred;
    logic       hit;
  } branch_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;   // is_conditional, pc, instr_size, next_pc, time_stamp
  logic         in_tuser = 1'b0; // is_branch
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;       // btb_hit, predicted, predicted_taken, mispredicted, stall_cycles
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [7:0]   cfg_wdata = '0;

  bimode_predictor_btb dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow predictor state
  logic [7:0]  mis_pen;
  logic [7:0]  miss_pen;
  logic [9:0]  hist;
  logic [1:0]  choice_ctr [PhtEntries];
  logic [1:0]  dir_ctr    [2*PhtEntries];
  logic [47:0] tag_mem    [BtbSets*BtbWays];
  logic [39:0] stamp_mem  [BtbSets*BtbWays];

  branch_res_t expected_res[$];
  int errors = 0;
  int n_sent = 0, n_hits = 0, n_preds = 0, n_mis = 0, n_checked = 0;

  // traffic shaping
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_off = 0;

  // address pool for random traffic, several pcs share a set to force evictions
  logic [47:0] pc_pool [32];
  bit          pool_bias [32];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [1:0] ctr_step(input logic [1:0] v, input logic up);
    if (up) return (v == 2'd3) ? 2'd3 : v + 2'd1;
    return (v == 2'd0) ? 2'd0 : v - 2'd1;
  endfunction

  // compute expected outcome and train the shadow tables
  function automatic branch_res_t predict_branch(input branch_rec_t r);
    branch_res_t res;
    int base, victim, w, hit_way, idx, dpos;
    logic [39:0] oldest;
    logic [1:0] ch;
    logic guess, taken, correct, disagree;
    res = '0;
    if (!r.is_branch) return res;
    base = int'(r.pc % BtbSets) * BtbWays;
    victim = 0;
    hit_way = -1;
    oldest = '1;
    for (w = 0; w < BtbWays; w++) begin
      if (hit_way < 0) begin
        if (tag_mem[base+w] == r.pc) hit_way = w;
        // strict less keeps the lowest way on a tie; all-ones start needs a first pick
        else if (w == 0 || stamp_mem[base+w] < oldest) begin
          oldest = stamp_mem[base+w];
          victim = w;
        end
      end
    end
    if (hit_way < 0) begin
      tag_mem[base+victim] = r.pc;
      stamp_mem[base+victim] = r.stamp;
      res.stall = miss_pen;
      return res;
    end
    stamp_mem[base+hit_way] = r.stamp;
    res.hit = 1'b1;
    if (!r.is_cond) return res;
    idx = int'((r.pc[9:0] ^ hist) % PhtEntries);
    ch = choice_ctr[idx];
    dpos = (ch >= 2 ? PhtEntries : 0) + idx;
    guess = dir_ctr[dpos] < 2;
    taken = ({1'b0, r.pc} + 49'(r.size)) != {1'b0, r.next_pc};
    correct = (guess == taken);
    disagree = (ch <= 1 && !taken) || (ch >= 2 && taken);
    if (!(correct && disagree)) choice_ctr[idx] = ctr_step(ch, !taken);
    dir_ctr[dpos] = ctr_step(dir_ctr[dpos], !taken);
    hist = {hist[8:0], correct};
    res.pred = 1'b1;
    res.pred_taken = guess;
    res.mispred = !correct;
    res.stall = correct ? 8'd0 : mis_pen;
    return res;
  endfunction

  // offer one record, hold it until the transfer, then queue its expectation
  task automatic send_rec(input branch_rec_t r);
    logic [143:0] packed_word;
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    packed_word = {3'b0, r.stamp, r.next_pc, r.size, r.pc, r.is_cond};
    in_tdata  <= packed_word;
    in_tuser  <= r.is_branch;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_res.push_back(predict_branch(r));
    n_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgMispredict[0:0]) mis_pen = val;
    else miss_pen = val;
  endtask

  function automatic branch_rec_t make_rec(input logic br, input logic cond,
      input logic [47:0] pc, input logic [3:0] size, input logic tk, input logic [39:0] st);
    branch_rec_t r;
    r.is_branch = br;
    r.is_cond = cond;
    r.pc = pc;
    r.size = size;
    r.next_pc = tk ? pc + 48'h1000 + 48'(size) : pc + 48'(size);
    r.stamp = st;
    return r;
  endfunction

  // checker: every transfer on the result side against the oldest expectation
  always @(posedge clk) begin
    branch_res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[11:0];
      if (expected_res.size() == 0) report_mismatch("result with nothing expected");
      else begin
        exp_r = expected_res.pop_front();
        n_checked++;
        if (got.hit != exp_r.hit)
          report_mismatch($sformatf("btb_hit %0b exp %0b", got.hit, exp_r.hit));
        if (got.pred != exp_r.pred)
          report_mismatch($sformatf("predicted %0b exp %0b", got.pred, exp_r.pred));
        if (got.pred_taken != exp_r.pred_taken)
          report_mismatch($sformatf("predicted_taken %0b exp %0b",
                                    got.pred_taken, exp_r.pred_taken));
        if (got.mispred != exp_r.mispred)
          report_mismatch($sformatf("mispredicted %0b exp %0b", got.mispred, exp_r.mispred));
        if (got.stall != exp_r.stall)
          report_mismatch($sformatf("stall_cycles %0d exp %0d", got.stall, exp_r.stall));
        if (exp_r.hit) n_hits++;
        if (exp_r.pred) n_preds++;
        if (exp_r.mispred) n_mis++;
      end
    end
  end

  // receiver readiness, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // directed: zero tag, unconditional hit, ignored conditional flag, carry, evictions
  task automatic test_directed;
    int k;
    send_rec(make_rec(1'b0, 1'b0, 48'h0, 4'h0, 1'b0, 40'h0));         // not a branch
    send_rec(make_rec(1'b0, 1'b1, 48'h123, 4'h4, 1'b1, 40'h1));        // cond without branch
    send_rec(make_rec(1'b1, 1'b1, 48'h0, 4'h4, 1'b1, 40'h2));          // pc 0 hits empty tag
    send_rec(make_rec(1'b1, 1'b1, 48'h0, 4'h4, 1'b0, 40'h3));
    send_rec(make_rec(1'b1, 1'b0, 48'h0, 4'hf, 1'b1, 40'h7));          // unconditional hit
    send_rec(make_rec(1'b1, 1'b1, 48'hffff_ffff_ffff, 4'hf, 1'b0, 40'h5)); // miss
    // fall-through carry: next_pc equals the wrapped sum but still counts as taken
    send_rec(make_rec(1'b1, 1'b1, 48'hffff_ffff_ffff, 4'hf, 1'b0, 40'h6));
    send_rec(make_rec(1'b1, 1'b1, 48'hffff_ffff_fff0, 4'h0, 1'b0, 40'h7));
    // six tags in set 0x155 force eviction and tie handling
    for (k = 0; k < 6; k++)
      send_rec(make_rec(1'b1, 1'b1, {38'(k + 1), 10'h155}, 4'(k), k[0], 40'(k % 3)));
    for (k = 0; k < 6; k++)
      send_rec(make_rec(1'b1, k[1], {38'(k + 1), 10'h155}, 4'(k * 3), !k[0], 40'(k)));
    send_rec(make_rec(1'b1, 1'b1, 48'haaaa_aaaa_aaaa, 4'ha, 1'b1, 40'hff_ffff_ffff));
    send_rec(make_rec(1'b1, 1'b1, 48'h5555_5555_5555, 4'h5, 1'b0, 40'h0));
    drain();
  endtask

  function automatic branch_rec_t rand_rec;
    branch_rec_t r;
    int p;
    logic tk;
    p = $urandom_range(31);
    r.is_branch = ($urandom_range(99) < 90);
    r.is_cond = ($urandom_range(99) < 75);
    r.pc = ($urandom_range(99) < 85) ? pc_pool[p] : 48'({$urandom, $urandom});
    r.size = 4'($urandom);
    r.stamp = 40'({$urandom, $urandom});
    tk = pool_bias[p] ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
    r.next_pc = tk ? 48'({$urandom, $urandom}) : r.pc + 48'(r.size);
    if ($urandom_range(99) < 3) r.pc = 48'hffff_ffff_ffff - 48'($urandom_range(7));
    return r;
  endfunction

  task automatic test_random(input int n, input int idle_in, input int stall_out);
    in_idle_pct = idle_in;
    out_stall_pct = stall_out;
    repeat (n) send_rec(rand_rec());
    drain();
  endtask

  // receiver holds off long enough for the block to back up onto its input
  task automatic test_backpressure;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_off = 300;
    repeat (60) send_rec(rand_rec());
    drain();
  endtask

  task automatic test_penalties;
    write_reg(CfgMispredict[0:0], 8'd0);
    write_reg(CfgBtbMiss[0:0], 8'd255);
    test_random(250, 0, 0);
    write_reg(CfgMispredict[0:0], 8'd255);
    write_reg(CfgBtbMiss[0:0], 8'd0);
    test_random(250, 54, 0);
    write_reg(CfgMispredict[0:0], 8'($urandom));
    write_reg(CfgBtbMiss[0:0], 8'($urandom));
  endtask

  initial begin
    int i;
    mis_pen = 8'd14;
    miss_pen = 8'd14;
    hist = '0;
    for (i = 0; i < PhtEntries; i++) begin
      choice_ctr[i] = 2'd0;
      dir_ctr[i] = 2'd0;
      dir_ctr[PhtEntries+i] = NtbReset;
    end
    for (i = 0; i < BtbSets*BtbWays; i++) begin
      tag_mem[i] = '0;
      stamp_mem[i] = '0;
    end
    for (i = 0; i < 32; i++) begin
      // 32 pcs spread at random over eight sets, keeps sets crowded
      pc_pool[i] = {{$urandom} % 38'd6, 10'(($urandom_range(7) * 129) & 10'h3ff)} ^
                   (i[0] ? 48'({$urandom, $urandom}) & 48'hffff_ffff_fc00 : 48'h0);
      pool_bias[i] = $urandom_range(1);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(250, 0, 0);
    test_random(350, 54, 0);
    test_penalties();
    test_random(350, 0, 54);
    test_random(250, 9, 9);
    test_backpressure();
    write_reg(CfgMispredict[0:0], 8'd14);
    write_reg(CfgBtbMiss[0:0], 8'd14);
    test_random(150, 54, 54);

    $display("covered %0d records: %0d checked, %0d btb hits, %0d predictions, %0d mispredicts",
             n_sent, n_checked, n_hits, n_preds, n_mis);
    $display("penalty registers swept over 0, 255 and random values with four idle mixes");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d transfers still expected", expected_res.size());
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/bpb_pkg.sv
hw/rtl/bpb_ctrl.sv
hw/rtl/bpb_dp.sv
hw/rtl/bimode_predictor_btb.sv
sim/tb.sv
